/* rtl/core/assert_macros.svh */
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, quiet while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/tmsf_pkg.sv */
package tmsf_pkg;

	// fixed field widths on the ports
	localparam int SAMPLE_FIELD_W = 12;
	localparam int DATA_W         = 16;
	localparam int USER_W         = 1;

	// control broadcast to every sorter cell
	typedef struct packed {
		logic insert;
		logic drain;
	} cell_ctrl_t;

endpackage

/* rtl/core/tmsf_cell.sv */
module tmsf_cell
	import tmsf_pkg::*;
#(
	parameter int W = 12
) (
	input  logic         clk,
	input  cell_ctrl_t   ctrl,
	input  logic         occ,
	input  logic [W-1:0] new_val,
	input  logic [W-1:0] left_val,
	input  logic         left_gt,
	input  logic [W-1:0] right_val,
	output logic [W-1:0] val,
	output logic         gt
);

	logic [W-1:0] val_q;

	// an empty cell counts as larger than anything
	assign gt  = !occ || (val_q > new_val);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt) begin
				val_q <= new_val;
			end
		end else if (ctrl.drain) begin
			val_q <= right_val;
		end
	end

endmodule

/* rtl/core/trimmed_mean_sample_filter_core.sv */
// after a window's last sample the sorter chain drains into the sum (ST_SUM),
//   the reciprocal multiplier scales it (ST_MUL) and ST_OUT waits for the
//   output register; throughput: one sample per cycle while a window fills,
//   and s_tready stays low until that window's result is loaded
// reset: arst_n asynchronous, active low, clears fill count, axis and handshakes
module trimmed_mean_sample_filter_core
	import tmsf_pkg::*;
#(
	parameter int SAMPLES     = 5,
	parameter int DROP        = 1,
	parameter int SAMPLE_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	// input words
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // [11:0] sample, [15:12] zero
	input  logic [USER_W-1:0] s_tuser,  // [0] axis
	// result words
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // [11:0] filtered, [15:12] zero
	output logic [USER_W-1:0] m_tuser   // [0] axis_out
);

	// trim is shrunk so that at least one sample survives
	localparam int TRIM   = (2 * DROP < SAMPLES) ? DROP : (SAMPLES - 1) / 2;
	localparam int KEPT   = SAMPLES - 2 * TRIM;
	localparam int SUM_W  = SAMPLE_BITS + 4;
	localparam int SHIFT  = SUM_W + 4;
	localparam int RCP_W  = SUM_W + 5;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam int CNT_W  = $clog2(SAMPLES + 1);
	localparam int IDX_W  = $clog2(SAMPLES);
	// rounded-up reciprocal, exact floor for any sum below 2**SUM_W
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << SHIFT) + 64'(KEPT) - 64'd1) / 64'(KEPT));

	localparam logic [1:0] ST_FILL = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       fill_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   axis_q;
	logic [SUM_W-1:0]       sum_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   m_valid_q;
	logic [SAMPLE_FIELD_W-1:0] m_filt_q;
	logic                   m_axis_q;

	logic                   in_acc;
	logic                   out_load;
	logic                   keep;
	logic [SAMPLE_BITS-1:0] new_val;
	cell_ctrl_t             ctrl;

	logic [SAMPLE_BITS-1:0] cell_val [SAMPLES];
	logic                   cell_gt  [SAMPLES];

	assign s_tready = (state_q == ST_FILL);
	assign in_acc   = s_tvalid && s_tready;
	// bits above SAMPLE_BITS are dropped, narrower fields zero-extend
	assign new_val  = SAMPLE_BITS'(s_tdata[SAMPLE_FIELD_W-1:0]);

	assign ctrl.insert = in_acc;
	assign ctrl.drain  = (state_q == ST_SUM);

	// sorted chain: cell 0 holds the smallest, drains towards cell 0
	for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] lval;
		logic                   lgt;
		logic [SAMPLE_BITS-1:0] rval;
		logic                   occ;

		if (i == 0) begin : g_first
			assign lval = new_val;
			assign lgt  = 1'b0;
		end else begin : g_mid
			assign lval = cell_val[i-1];
			assign lgt  = cell_gt[i-1];
		end

		if (i == SAMPLES - 1) begin : g_last
			assign rval = cell_val[i];
		end else begin : g_inner
			assign rval = cell_val[i+1];
		end

		assign occ = (CNT_W'(i) < fill_q);

		tmsf_cell #(
			.W (SAMPLE_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ),
			.new_val   (new_val),
			.left_val  (lval),
			.left_gt   (lgt),
			.right_val (rval),
			.val       (cell_val[i]),
			.gt        (cell_gt[i])
		);
	end

	// only the middle ranks go into the sum
	assign keep = (idx_q >= IDX_W'(TRIM)) && (idx_q <= IDX_W'(SAMPLES - TRIM - 1));

	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			idx_q   <= '0;
			axis_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (in_acc) begin
						if (fill_q == '0) begin
							axis_q <= s_tuser[0];
						end
						if (fill_q == CNT_W'(SAMPLES - 1)) begin
							fill_q  <= '0;
							idx_q   <= '0;
							state_q <= ST_SUM;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_SUM: begin
					if (idx_q == IDX_W'(SAMPLES - 1)) begin
						state_q <= ST_MUL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	// accumulator and scaling product
	always_ff @(posedge clk) begin
		if (in_acc && (fill_q == CNT_W'(SAMPLES - 1))) begin
			sum_q <= '0;
		end else if ((state_q == ST_SUM) && keep) begin
			sum_q <= sum_q + SUM_W'(cell_val[0]);
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
		end
	end

	// output register, the fill side keeps going while a word waits here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_filt_q <= prod_q[SHIFT +: SAMPLE_FIELD_W];
			m_axis_q <= axis_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(DATA_W - SAMPLE_FIELD_W){1'b0}}, m_filt_q};
	assign m_tuser  = m_axis_q;

endmodule

/* rtl/core/tmsf_checker.sv */
`include "assert_macros.svh"

module tmsf_checker #(
	parameter int SAMPLES = 5
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);

	localparam int IDX_W = $clog2(SAMPLES);

	logic             s_acc;
	logic [IDX_W-1:0] acc_cnt_q;
	logic             win_end;

	assign s_acc   = s_tvalid && s_tready;
	assign win_end = s_acc && (acc_cnt_q == IDX_W'(SAMPLES - 1));

	// position of the next word within its window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q <= '0;
		end else if (win_end) begin
			acc_cnt_q <= '0;
		end else if (s_acc) begin
			acc_cnt_q <= acc_cnt_q + 1'b1;
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	`ASSERT_NEXT(a_window_stall, clk, arst_n, win_end, !s_tready)
	`ASSERT_IMPLY(a_result_after_drain, clk, arst_n, $rose(m_tvalid), !$past(s_tready))
	`ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[15:12] == 4'd0)

endmodule

bind trimmed_mean_sample_filter_core tmsf_checker #(
	.SAMPLES (SAMPLES)
) u_tmsf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
